// ===== rtl/dswma_pkg.sv =====
// ----------------------------------------------------------------------------
// dswma_pkg
// Types and constants shared by the dual sensor weighted moving average.
// ----------------------------------------------------------------------------
package dswma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HELD_W   = 4;
  // weight of the oldest held sample
  localparam int BASE_WGT = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_reading;
    logic                       first_ok;
    logic signed [SAMPLE_W-1:0] second_reading;
    logic                       second_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed_value;
    logic                       fault;
    logic [HELD_W-1:0]          samples_held;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/dswma_chan_if.sv =====
// ----------------------------------------------------------------------------
// dswma_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface dswma_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dswma_ring.sv =====
// ----------------------------------------------------------------------------
// dswma_ring
// History ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dswma_ring
  import dswma_pkg::*;
#(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/dswma_div.sv =====
// ----------------------------------------------------------------------------
// dswma_div
// Serial restoring divider, one quotient bit per cycle. Returns
// num/den rounded to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module dswma_div
  import dswma_pkg::*;
#(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]           den,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quot
);

  localparam int DIVD_W = NUM_W + 1;
  localparam int DCNT_W = $clog2(DIVD_W + 1);
  localparam int REM_W  = DEN_W + 2;

  logic [DIVD_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W:0]    dvs_r, dvs_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [NUM_W-1:0]  mag;
  logic [REM_W-1:0]  rem_sh;
  logic              qbit;

  always_comb begin
    mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rem_sh   = {rem_r[REM_W-2:0], dvd_r[DIVD_W-1]};
    qbit     = (rem_sh >= {1'b0, dvs_r});
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // (2|num| + den) / (2 den)
      dvd_nxt  = {mag, 1'b0} + DIVD_W'(den);
      dvs_nxt  = {den, 1'b0};
      rem_nxt  = '0;
      cnt_nxt  = DCNT_W'(DIVD_W);
      neg_nxt  = num[NUM_W-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      dvd_nxt = {dvd_r[DIVD_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // magnitude never exceeds 32768, so the low bits carry the whole result
  assign done = done_r;
  assign quot = neg_r ? -$signed(dvd_r[SAMPLE_W-1:0]) : $signed(dvd_r[SAMPLE_W-1:0]);

endmodule

// ===== rtl/dual_sensor_weighted_moving_average.sv =====
// ----------------------------------------------------------------------------
// dual_sensor_weighted_moving_average
// Merges two sensor readings into one sample, keeps a ring of recent
// samples and returns their linearly weighted mean.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  in_ch    | in  | first_reading, first_ok, second_reading, second_ok
//  out_ch   | out | smoothed_value, fault, samples_held
//
//  One item at a time. An accepted sample takes one ring read per held
//  sample, then a one-bit-per-cycle divider of 17 + DEN_W steps; a fault
//  item skips both and goes straight to the output stage.
//  Reset clears the write slot and fill count; ring entries are only read
//  after being written, so no clearing pass is needed.
//  A stalled result waits in the output register; the next item is taken.
// ----------------------------------------------------------------------------
module dual_sensor_weighted_moving_average
  import dswma_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input logic          clk,
  input logic          rst_n,
  dswma_chan_if.sink   in_ch,
  dswma_chan_if.source out_ch
);

  localparam int ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int WGT_W  = $clog2(BASE_WGT + HISTORY_DEPTH);
  localparam int DEN_W  = $clog2(HISTORY_DEPTH * (BASE_WGT + HISTORY_DEPTH));
  localparam int NUM_W  = SAMPLE_W + DEN_W;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [ADDR_W-1:0]       ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        left_r, left_nxt;
  logic [WGT_W-1:0]        weight_r, weight_nxt;
  logic [WGT_W-1:0]        wd_r, wd_nxt;
  logic                    rdv_r, rdv_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  out_item_t               res_r, res_nxt;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic in_ready, in_xfer, any_ok, both_ok;
  logic ring_wr, rd_en, div_start, out_load, div_done;
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W-1:0] raw;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] div_q;
  logic signed [NUM_W-1:0]    samp_ext, wgt_ext, prod;
  logic [ADDR_W-1:0]          slot_inc, ptr_dec;
  logic [CNT_W-1:0]           fill_inc;

  assign in_xfer  = in_ch.valid && in_ready;
  assign any_ok   = in_ch.data.first_ok || in_ch.data.second_ok;
  assign both_ok  = in_ch.data.first_ok && in_ch.data.second_ok;
  assign pair_sum = {in_ch.data.first_reading[SAMPLE_W-1], in_ch.data.first_reading}
                  + {in_ch.data.second_reading[SAMPLE_W-1], in_ch.data.second_reading};
  // floor of half the sum
  assign raw = both_ok ? pair_sum[SAMPLE_W:1] :
               in_ch.data.first_ok ? in_ch.data.first_reading :
               in_ch.data.second_reading;

  assign slot_inc = (slot_r == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign ptr_dec  = (ptr_r == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : ptr_r - 1'b1;
  assign fill_inc = (fill_r == CNT_W'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;

  assign samp_ext = NUM_W'(rd_data);
  assign wgt_ext  = $signed(NUM_W'(wd_r));
  assign prod     = samp_ext * wgt_ext;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = any_ok ? ST_WALK : ST_OUT;
        end
      end
      ST_WALK: begin
        if (left_r == '0 && !rdv_r) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    ring_wr   = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ring_wr  = in_ch.valid && any_ok;
      end
      ST_WALK: begin
        rd_en     = (left_r != '0);
        div_start = (left_r == '0) && !rdv_r;
      end
      ST_DIV: begin
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    weight_nxt    = weight_r;
    wd_nxt        = weight_r;
    rdv_nxt       = rd_en;
    num_nxt       = num_r;
    den_nxt       = den_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (ring_wr) begin
      slot_nxt   = slot_inc;
      fill_nxt   = fill_inc;
      ptr_nxt    = slot_r;
      left_nxt   = fill_inc;
      weight_nxt = WGT_W'(BASE_WGT - 1) + WGT_W'(fill_inc);
      num_nxt    = '0;
      den_nxt    = '0;
    end else if (in_xfer) begin
      res_nxt.smoothed_value = '0;
      res_nxt.fault          = 1'b1;
      res_nxt.samples_held   = HELD_W'(fill_r);
    end

    if (rd_en) begin
      ptr_nxt    = ptr_dec;
      left_nxt   = left_r - 1'b1;
      weight_nxt = weight_r - 1'b1;
    end

    if (rdv_r) begin
      num_nxt = num_r + prod;
      den_nxt = den_r + DEN_W'(wd_r);
    end

    if (div_done) begin
      res_nxt.smoothed_value = div_q;
      res_nxt.fault          = 1'b0;
      res_nxt.samples_held   = HELD_W'(fill_r);
    end

    if (out_load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      left_r      <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    weight_r <= weight_nxt;
    wd_r     <= wd_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  dswma_ring #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (slot_r),
    .wr_data (raw),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  dswma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

// ===== tb/dual_sensor_weighted_moving_average_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_sensor_weighted_moving_average_tb
// Drives merged sensor readings through the weighted moving average and
// compares every result against a cycle-free predictor of the sample ring,
// the fill count and the rounded weighted mean. Directed cases cover the
// merge rules, range extremes and rounding ties, then a long random stream
// runs with random idle gaps on either channel, switched per segment.
// ----------------------------------------------------------------------------
module dual_sensor_weighted_moving_average_tb;
  import dswma_pkg::*;

  localparam int DEPTH       = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1280;
  localparam int SEGMENT     = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dswma_chan_if #(.T(in_item_t))  in_ch ();
  dswma_chan_if #(.T(out_item_t)) out_ch ();

  dual_sensor_weighted_moving_average #(
    .HISTORY_DEPTH(DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  int        hist_model [DEPTH];
  int        next_slot = 0;
  int        held_count = 0;
  out_item_t pending_avg [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_gaps = 1'b1;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Updates the ring model for one accepted item and returns the result.
  function automatic out_item_t predict_smoothed(in_item_t it);
    out_item_t r;
    int        sample;
    int        idx;
    longint    acc;
    longint    wsum;
    longint    w;
    longint    q;
    r = '0;
    if (!it.first_ok && !it.second_ok) begin
      r.fault        = 1'b1;
      r.samples_held = HELD_W'(held_count);
      return r;
    end
    if (it.first_ok && it.second_ok)
      sample = (int'(it.first_reading) + int'(it.second_reading)) >>> 1;
    else if (it.first_ok)
      sample = int'(it.first_reading);
    else
      sample = int'(it.second_reading);
    hist_model[next_slot] = sample;
    next_slot = (next_slot + 1) % DEPTH;
    if (held_count < DEPTH)
      held_count++;
    acc  = 0;
    wsum = 0;
    // newest sample carries the heaviest weight
    for (int i = 0; i < held_count; i++) begin
      idx  = (next_slot + 2 * DEPTH - 1 - i) % DEPTH;
      w    = BASE_WGT + held_count - 1 - i;
      acc  += longint'(hist_model[idx]) * w;
      wsum += w;
    end
    // round half away from zero
    if (acc >= 0)
      q = (2 * acc + wsum) / (2 * wsum);
    else
      q = -((-2 * acc + wsum) / (2 * wsum));
    r.smoothed_value = SAMPLE_W'(q);
    r.fault          = 1'b0;
    r.samples_held   = HELD_W'(held_count);
    return r;
  endfunction

  function automatic in_item_t mk_item(int a, bit a_ok, int b, bit b_ok);
    in_item_t it;
    it.first_reading  = SAMPLE_W'(a);
    it.first_ok       = a_ok;
    it.second_reading = SAMPLE_W'(b);
    it.second_ok      = b_ok;
    return it;
  endfunction

  function automatic int rand_reading();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: return int'($signed(16'($urandom)));
      2: begin
        case ($urandom_range(0, 4))
          0: return 32767;
          1: return -32768;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return int'($urandom_range(0, 1000)) - 500;
    endcase
  endfunction

  // Sends one item; the expectation is formed at the transfer.
  task automatic send_reading(in_item_t it);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_avg.push_back(predict_smoothed(it));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_avg.size() != 0) @(posedge clk);
  endtask

  // result side: random stall per result, check on each transfer
  initial begin
    int        stall;
    out_item_t exp_item;
    out_item_t got;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = rx_gaps ? $urandom_range(0, 5) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got = out_ch.data;
      if (pending_avg.size() == 0) begin
        $error("unexpected result: smoothed_value %0d fault %0d samples_held %0d",
               got.smoothed_value, got.fault, got.samples_held);
        mismatch_count++;
      end else begin
        exp_item = pending_avg.pop_front();
        if (got.smoothed_value !== exp_item.smoothed_value) begin
          $error("smoothed_value: expected %0d, actual %0d",
                 exp_item.smoothed_value, got.smoothed_value);
          mismatch_count++;
        end
        if (got.fault !== exp_item.fault) begin
          $error("fault: expected %0d, actual %0d", exp_item.fault, got.fault);
          mismatch_count++;
        end
        if (got.samples_held !== exp_item.samples_held) begin
          $error("samples_held: expected %0d, actual %0d",
                 exp_item.samples_held, got.samples_held);
          mismatch_count++;
        end
      end
    end
  end

  // Fill growth from empty, rounding ties both signs, filling the ring to full depth.
  task automatic test_fill_and_ties();
    send_reading(mk_item(32767, 1'b0, -32768, 1'b0));  // fault on empty ring
    send_reading(mk_item(0, 1'b1, 0, 1'b0));
    send_reading(mk_item(0, 1'b0, 0, 1'b1));
    send_reading(mk_item(0, 1'b1, 0, 1'b1));
    send_reading(mk_item(23, 1'b1, 0, 1'b0));           // 299/46: positive tie
    send_reading(mk_item(0, 1'b1, 0, 1'b0));
    send_reading(mk_item(0, 1'b0, 0, 1'b1));
    send_reading(mk_item(0, 1'b1, 0, 1'b0));
    send_reading(mk_item(-97, 1'b0, -97, 1'b1));        // -1350/108: negative tie
    wait_drained();
  endtask

  // Merge rules at the range extremes, floor on odd sums, ignored readings.
  task automatic test_merge_extremes();
    send_reading(mk_item(32767, 1'b1, 32767, 1'b1));
    send_reading(mk_item(-32768, 1'b1, -32768, 1'b1));
    send_reading(mk_item(32767, 1'b1, -32768, 1'b1));   // floor of -0.5
    send_reading(mk_item(-1, 1'b1, 0, 1'b1));
    send_reading(mk_item(1, 1'b1, 2, 1'b1));
    send_reading(mk_item(32767, 1'b1, -32768, 1'b0));
    send_reading(mk_item(32767, 1'b0, -32768, 1'b1));
    send_reading(mk_item(-1, 1'b0, -1, 1'b0));          // fault on full ring
    send_reading(mk_item(-32768, 1'b1, 12345, 1'b0));
    send_reading(mk_item(-5555, 1'b0, 32767, 1'b1));
    wait_drained();
  endtask

  // Long random stream; gap modes rotate by segment.
  task automatic test_random_stream();
    int       a;
    int       b;
    int       kind;
    in_item_t it;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT == 0) begin
        tx_gaps = ((n / SEGMENT) % 4) inside {0, 2};
        rx_gaps = ((n / SEGMENT) % 4) inside {0, 1};
      end
      a    = rand_reading();
      b    = rand_reading();
      kind = $urandom_range(0, 19);
      if (kind < 3)
        it = mk_item(a, 1'b0, b, 1'b0);
      else if (kind < 7)
        it = mk_item(a, 1'b1, b, 1'b0);
      else if (kind < 11)
        it = mk_item(a, 1'b0, b, 1'b1);
      else
        it = mk_item(a, 1'b1, b, 1'b1);
      send_reading(it);
      // one full hold-off in mid stream
      if (n == RANDOM_ITEMS / 2)
        wait_drained();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_ties();
    test_merge_extremes();
    test_random_stream();

    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dswma_pkg.sv
rtl/dswma_chan_if.sv
rtl/dswma_ring.sv
rtl/dswma_div.sv
rtl/dual_sensor_weighted_moving_average.sv
tb/dual_sensor_weighted_moving_average_tb.sv
